FILE: sv/sil_pkg.sv
// Shared types and breakpoint tables for the interpolated sine lookup.
`default_nettype none
package sil_pkg;

    localparam int SEG_COUNT = 21;
    localparam int BP_COUNT  = 22;
    localparam int RECIP_SHIFT = 15;

    typedef logic [4:0]        seg_t;
    typedef logic [3:0]        off_t;
    typedef logic signed [7:0] sine_t;

    // Breakpoint x positions (one full period, closed by the point at 256).
    localparam logic [8:0] BP_X [0:BP_COUNT-1] = '{
        9'd0,   9'd13,  9'd26,  9'd38,  9'd51,  9'd64,  9'd77,  9'd90,
        9'd102, 9'd115, 9'd128, 9'd141, 9'd154, 9'd166, 9'd179,
        9'd192, 9'd205, 9'd218, 9'd230, 9'd243, 9'd255, 9'd256};

    localparam sine_t BP_Y [0:BP_COUNT-1] = '{
        8'sd0,    8'sd39,   8'sd75,   8'sd103,  8'sd121,  8'sd127,  8'sd121,
        8'sd103,  8'sd75,   8'sd39,   8'sd0,    -8'sd39,  -8'sd75,  -8'sd103,
        -8'sd121, -8'sd127, -8'sd121, -8'sd103, -8'sd75,  -8'sd39,  8'sd0,
        8'sd0};

    // Rise of each segment, y2 - y1.
    localparam logic signed [6:0] SEG_DY [0:SEG_COUNT-1] = '{
        7'sd39,  7'sd36,  7'sd28,  7'sd18,  7'sd6,   -7'sd6,  -7'sd18,
        -7'sd28, -7'sd36, -7'sd39, -7'sd39, -7'sd36, -7'sd28, -7'sd18,
        -7'sd6,  7'sd6,   7'sd18,  7'sd28,  7'sd36,  7'sd39,  7'sd0};

    // ceil(2^15 / run) for each segment; runs are 13, 12 or 1.
    localparam logic [15:0] SEG_RECIP [0:SEG_COUNT-1] = '{
        16'd2521, 16'd2521, 16'd2731, 16'd2521, 16'd2521, 16'd2521, 16'd2521,
        16'd2731, 16'd2521, 16'd2521, 16'd2521, 16'd2521, 16'd2731, 16'd2521,
        16'd2521, 16'd2521, 16'd2521, 16'd2731, 16'd2521, 16'd2731, 16'd32768};

    typedef struct packed {
        seg_t seg;
        off_t off;
    } seg_stage_t;

    typedef struct packed {
        seg_t        seg;
        logic        neg;
        logic [20:0] mul;
    } scale_stage_t;

endpackage
`default_nettype wire

FILE: sv/sil_seg.sv
// Stage 1: segment select and offset within the segment.
`default_nettype none
module sil_seg
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire logic [7:0]           angle,
    output logic                      dn_valid,
    input  wire logic                 dn_ready,
    output sil_pkg::seg_stage_t       dn_data
);

    logic                valid_reg;
    sil_pkg::seg_stage_t data_reg;
    sil_pkg::seg_stage_t data_next;
    logic                advance;
    logic [8:0]          diff;

    assign advance  = !valid_reg || dn_ready;
    assign up_ready = advance;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        data_next.seg = '0;
        // Last breakpoint at or below the angle; the table is ascending.
        for (int k = 1; k < sil_pkg::SEG_COUNT; k++)
        begin
            if ({1'b0, angle} >= sil_pkg::BP_X[k])
            begin
                data_next.seg = sil_pkg::seg_t'(k);
            end
        end
        diff          = {1'b0, angle} - sil_pkg::BP_X[data_next.seg];
        data_next.off = diff[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    a_off_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.off <= 4'd12 && data_reg.seg < 5'd21))
        else $error("segment offset out of range");

endmodule
`default_nettype wire

FILE: sv/sil_scale.sv
// Stages 2 and 3: rise times offset, then scale by the reciprocal of the run.
`default_nettype none
module sil_scale
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  up_valid,
    output logic                       up_ready,
    input  wire sil_pkg::seg_stage_t   up_data,
    output logic                       dn_valid,
    input  wire logic                  dn_ready,
    output sil_pkg::scale_stage_t      dn_data
);

    logic                  prod_valid_reg;
    sil_pkg::seg_t         prod_seg_reg;
    logic signed [11:0]    prod_reg;
    logic signed [11:0]    prod_next;
    logic                  mul_valid_reg;
    sil_pkg::scale_stage_t mul_reg;
    sil_pkg::scale_stage_t mul_next;
    logic                  prod_advance;
    logic                  mul_advance;
    logic [8:0]            mag;
    logic [24:0]           full;

    assign mul_advance  = !mul_valid_reg || dn_ready;
    assign prod_advance = !prod_valid_reg || mul_advance;
    assign up_ready     = prod_advance;
    assign dn_valid     = mul_valid_reg;
    assign dn_data      = mul_reg;

    assign prod_next = sil_pkg::SEG_DY[up_data.seg] * $signed({1'b0, up_data.off});

    always_comb
    begin
        mul_next.seg = prod_seg_reg;
        mul_next.neg = prod_reg[11];
        // Take the magnitude so the scaled quotient truncates toward zero.
        mag          = prod_reg[11] ? 9'(-prod_reg) : prod_reg[8:0];
        full         = mag * sil_pkg::SEG_RECIP[prod_seg_reg];
        mul_next.mul = full[20:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            mul_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_advance)
            begin
                prod_valid_reg <= up_valid;
            end
            if (mul_advance)
            begin
                mul_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_advance && up_valid)
        begin
            prod_reg     <= prod_next;
            prod_seg_reg <= up_data.seg;
        end
        if (mul_advance && prod_valid_reg)
        begin
            mul_reg <= mul_next;
        end
    end

    a_prod_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg |-> (prod_reg <= 12'sd468 && prod_reg >= -12'sd468))
        else $error("segment product out of range");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mul_valid_reg |-> (mul_reg.mul[20:15] <= 6'd39))
        else $error("scaled quotient exceeds largest rise");

endmodule
`default_nettype wire

FILE: sv/sil_fin.sv
// Stage 4: apply sign, add the segment base, hold the result for the consumer.
`default_nettype none
module sil_fin
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  up_valid,
    output logic                       up_ready,
    input  wire sil_pkg::scale_stage_t up_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output sil_pkg::sine_t             sine_value
);

    logic               valid_reg;
    sil_pkg::sine_t     value_reg;
    logic signed [8:0]  quot;
    logic signed [8:0]  sum;
    logic               advance;

    assign advance    = !valid_reg || !out_stall;
    assign up_ready   = advance;
    assign out_valid  = valid_reg;
    assign sine_value = value_reg;

    always_comb
    begin
        quot = $signed({3'b000, up_data.mul[20:sil_pkg::RECIP_SHIFT]});
        if (up_data.neg)
        begin
            quot = -quot;
        end
        sum = 9'(sil_pkg::BP_Y[up_data.seg]) + quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            value_reg <= sum[7:0];
        end
    end

endmodule
`default_nettype wire

FILE: sv/sine_interp_lookup.sv
// Top level: four-stage sine lookup with linear interpolation between breakpoints.
//
//   channel  | valid      | stall      | payload
//   ---------+------------+------------+--------------------------
//   input    | in_valid   | in_stall   | angle       [7:0] unsigned
//   output   | out_valid  | out_stall  | sine_value  [7:0] signed
//
// An accepted angle passes the segment, product, scale and output registers in turn.
// One transaction enters per cycle while in_stall is low; the segment compare, the rise
// multiply, the reciprocal multiply and the final add each take one register stage.
// Reset clears the stage valid bits only; the data registers are not reset.
// A stall on the output backs up through the stages; in_stall rises only when
// every stage holds a transaction.
`default_nettype none
module sine_interp_lookup
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            angle,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [7:0]          sine_value
);

    logic                  seg_ready;
    logic                  seg_valid;
    sil_pkg::seg_stage_t   seg_data;
    logic                  scale_ready;
    logic                  scale_valid;
    sil_pkg::scale_stage_t scale_data;
    logic                  fin_ready;

    assign in_stall = !seg_ready;

    sil_seg u_seg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (seg_ready),
        .angle    (angle),
        .dn_valid (seg_valid),
        .dn_ready (scale_ready),
        .dn_data  (seg_data)
    );

    sil_scale u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (seg_valid),
        .up_ready (scale_ready),
        .up_data  (seg_data),
        .dn_valid (scale_valid),
        .dn_ready (fin_ready),
        .dn_data  (scale_data)
    );

    sil_fin u_fin
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (scale_valid),
        .up_ready   (fin_ready),
        .up_data    (scale_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sine_value (sine_value)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && seg_valid && scale_valid))
        else $error("input stalled with an empty stage");

    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sine_value <= 8'sd127 && sine_value >= -8'sd127))
        else $error("sine value out of range");

endmodule
`default_nettype wire
